// ===== src/efns_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efns_pkg
// Shared types, codes and field layout of the exchange field neighbor sum block.
// ----------------------------------------------------------------------------
package efns_pkg;

  localparam int DEF_ATOMS         = 1024;
  localparam int DEF_ENSEMBLES     = 8;
  localparam int DEF_MAX_NEIGHBORS = 64;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_WR_MOMENT = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_SLOT   = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_COUNT = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE   = 2'd3;

  localparam int SITE_W  = 10;
  localparam int ENS_W   = 3;
  localparam int SLOT_W  = 6;
  localparam int NBR_W   = 10;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 7;

  localparam int S_TDATA_W = 168;
  localparam int M_TDATA_W = 112;

  // widest command fields over the parameter ranges
  localparam int SLOT_IDX_W = 8;
  localparam int ATOM_IDX_W = 16;
  localparam int CNT_STAT_W = 9;

  typedef struct packed {
    logic                  accept;
    logic                  start;
    logic                  issue;
    logic [SLOT_IDX_W-1:0] slot_idx;
    logic                  clr_en;
    logic [ATOM_IDX_W-1:0] clr_addr;
    logic                  finish;
  } cmd_t;

  typedef struct packed {
    logic [CNT_STAT_W-1:0] count;
    logic                  out_free;
  } status_t;

endpackage

// ===== src/efns_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efns_ctrl
// Sequencer: count memory clear after reset, item intake, neighbor walk,
// pipeline drain and result hand-off.
// ----------------------------------------------------------------------------
module efns_ctrl #(
  parameter int ATOMS         = efns_pkg::DEF_ATOMS,
  parameter int MAX_NEIGHBORS = efns_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic [efns_pkg::OP_W-1:0] op,
  output logic                      s_tready,
  input  efns_pkg::status_t         status,
  output efns_pkg::cmd_t            cmd
);

  localparam int ATOM_W = $clog2(ATOMS);
  localparam int J_W    = $clog2(MAX_NEIGHBORS + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]        state, state_next;
  logic [ATOM_W-1:0] clr_addr, clr_addr_next;
  logic [J_W-1:0]    j, j_next;
  logic [1:0]        drain, drain_next;
  logic [J_W-1:0]    n;

  assign n = status.count[J_W-1:0];

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    j_next        = j;
    drain_next    = drain;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.slot_idx  = efns_pkg::SLOT_IDX_W'(j);
    cmd.clr_addr  = efns_pkg::ATOM_IDX_W'(clr_addr);
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en    = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ATOM_W'(ATOMS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && op == efns_pkg::OP_COMPUTE) begin
          cmd.start  = 1'b1;
          j_next     = '0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (j == n) begin
          drain_next = '0;
          state_next = S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          j_next    = j + 1'b1;
        end
      end
      S_DRAIN: begin
        drain_next = drain + 1'b1;
        if (drain == 2'd2) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      j        <= '0;
      drain    <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      j        <= j_next;
      drain    <= drain_next;
    end
  end

`ifndef SYNTH
  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> j <= n)
    else $error("walk index past neighbor count");

  a_issue_below_count: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> j < n && state == S_WALK)
    else $error("slot read issued outside the count");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> state == S_CLEAR && clr_addr == '0)
    else $error("clear pass not restarted by reset");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free && !s_tready)
    else $error("result loaded while output busy");
`endif

endmodule

// ===== src/efns_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efns_dpath
// Moment, slot and count memories, four-stage multiply-accumulate pipeline,
// saturation and the output register.
// ----------------------------------------------------------------------------
module efns_dpath #(
  parameter int ATOMS         = efns_pkg::DEF_ATOMS,
  parameter int ENSEMBLES     = efns_pkg::DEF_ENSEMBLES,
  parameter int MAX_NEIGHBORS = efns_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  efns_pkg::cmd_t                 cmd,
  output efns_pkg::status_t              status,
  input  logic [efns_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [efns_pkg::OP_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [efns_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser
);

  localparam int ATOM_W = $clog2(ATOMS);
  localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int MOM_AW = $clog2(ATOMS * ENSEMBLES);
  localparam int NB_AW  = $clog2(ATOMS * MAX_NEIGHBORS);
  localparam int VW     = efns_pkg::VAL_W;
  localparam int RND_W  = 2 * VW - 16;
  localparam int ACC_W  = RND_W + CNT_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

  logic [efns_pkg::SITE_W-1:0]  in_site;
  logic [efns_pkg::ENS_W-1:0]   in_ens;
  logic [efns_pkg::SLOT_W-1:0]  in_slot;
  logic [efns_pkg::NBR_W-1:0]   in_nbr;
  logic [VW-1:0]                in_coup;
  logic [efns_pkg::COUNT_W-1:0] in_count;
  logic [3*VW-1:0]              in_vec;

  assign in_site  = s_tdata[9:0];
  assign in_ens   = s_tdata[12:10];
  assign in_slot  = s_tdata[18:13];
  assign in_nbr   = s_tdata[28:19];
  assign in_coup  = s_tdata[60:29];
  assign in_count = s_tdata[67:61];
  assign in_vec   = s_tdata[163:68];

  logic site_ok, ens_ok, slot_ok;
  assign site_ok = 32'(in_site) < 32'(ATOMS);
  assign ens_ok  = 32'(in_ens) < 32'(ENSEMBLES);
  assign slot_ok = 32'(in_slot) < 32'(MAX_NEIGHBORS);

  logic wr_mom, wr_slot, wr_cnt;
  assign wr_mom  = cmd.accept && s_tuser == efns_pkg::OP_WR_MOMENT && site_ok && ens_ok;
  assign wr_slot = cmd.accept && s_tuser == efns_pkg::OP_WR_SLOT && site_ok && slot_ok;
  assign wr_cnt  = cmd.accept && s_tuser == efns_pkg::OP_SET_COUNT && site_ok;

  // item registers
  logic [efns_pkg::SITE_W-1:0] site_r;
  logic [efns_pkg::ENS_W-1:0]  ens_r;
  logic [3*VW-1:0]             ext_r;
  logic                        range_ok;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      site_r   <= in_site;
      ens_r    <= in_ens;
      ext_r    <= in_vec;
      range_ok <= site_ok && ens_ok;
    end
  end

  // neighbor counts
  logic [CNT_W-1:0] cnt_mem [ATOMS];
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_wdata;

  assign cnt_wdata = (32'(in_count) > 32'(MAX_NEIGHBORS)) ? CNT_W'(MAX_NEIGHBORS)
                                                          : CNT_W'(in_count);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      cnt_mem[cmd.clr_addr[ATOM_W-1:0]] <= '0;
    end else if (wr_cnt) begin
      cnt_mem[ATOM_W'(in_site)] <= cnt_wdata;
    end
    if (cmd.start) begin
      cnt_q <= cnt_mem[ATOM_W'(in_site)];
    end
  end

  assign status.count    = range_ok ? efns_pkg::CNT_STAT_W'(cnt_q) : '0;
  assign status.out_free = !m_tvalid || m_tready;

  // neighbor slots: {coupling, neighbor}
  logic [VW+efns_pkg::NBR_W-1:0] slot_mem [ATOMS * MAX_NEIGHBORS];
  logic [VW+efns_pkg::NBR_W-1:0] slot_q;
  logic [NB_AW-1:0]              slot_wa, slot_ra;

  assign slot_wa = NB_AW'(32'(in_site) * 32'(MAX_NEIGHBORS) + 32'(in_slot));
  assign slot_ra = NB_AW'(32'(site_r) * 32'(MAX_NEIGHBORS) + 32'(cmd.slot_idx));

  always_ff @(posedge clk) begin
    if (wr_slot) begin
      slot_mem[slot_wa] <= {in_coup, in_nbr};
    end
    if (cmd.issue) begin
      slot_q <= slot_mem[slot_ra];
    end
  end

  // moments: {z, y, x}
  logic [3*VW-1:0]   mom_mem [ATOMS * ENSEMBLES];
  logic [3*VW-1:0]   mom_q;
  logic [MOM_AW-1:0] mom_wa, mom_ra;
  logic              nb_ok;
  logic              s1_v, s2_v, s3_v;
  logic [VW-1:0]     coup2;

  assign nb_ok  = 32'(slot_q[efns_pkg::NBR_W-1:0]) < 32'(ATOMS);
  assign mom_wa = MOM_AW'(32'(in_ens) * 32'(ATOMS) + 32'(in_site));
  assign mom_ra = MOM_AW'(32'(ens_r) * 32'(ATOMS) + 32'(slot_q[efns_pkg::NBR_W-1:0]));

  always_ff @(posedge clk) begin
    if (wr_mom) begin
      mom_mem[mom_wa] <= in_vec;
    end
    if (s1_v) begin
      mom_q <= mom_mem[mom_ra];
      coup2 <= slot_q[VW+efns_pkg::NBR_W-1:efns_pkg::NBR_W];
    end
  end

  // multiply and accumulate
  logic signed [2*VW-1:0] prod [3];
  logic signed [2*VW-1:0] prod_r [3];
  logic signed [ACC_W-1:0] acc [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v && nb_ok;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod[c] <= $signed(coup2) * $signed(mom_q[c*VW +: VW]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_r[c] = prod[c] + (2*VW)'(32768);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.start) begin
        acc[c] <= '0;
      end else if (s3_v) begin
        acc[c] <= acc[c] + ACC_W'($signed(prod_r[c][2*VW-1:16]));
      end
    end
  end

  // external field, saturation and output register
  logic signed [ACC_W-1:0] sum [3];
  logic [VW-1:0]           fld [3];
  logic [2:0]              clip;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = acc[c] + ACC_W'($signed(ext_r[c*VW +: VW]));
      if (sum[c] > SAT_HI) begin
        fld[c]  = SAT_HI[VW-1:0];
        clip[c] = 1'b1;
      end else if (sum[c] < SAT_LO) begin
        fld[c]  = SAT_LO[VW-1:0];
        clip[c] = 1'b1;
      end else begin
        fld[c]  = sum[c][VW-1:0];
        clip[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {3'b000, fld[2], fld[1], fld[0], ens_r, site_r};
      m_tuser <= |clip;
    end
  end

endmodule

// ===== src/exchange_field_neighbor_sum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exchange_field_neighbor_sum_top
// Neighbor-list exchange field engine with moment, slot and count tables.
// ----------------------------------------------------------------------------
// After reset the block clears its neighbor count table, one site per cycle,
// and takes no transfer until the clear is done. A moment, slot or count
// write leaves the block idle and ready for the next transfer. A compute
// item runs from acceptance to a loaded result, and the next transfer is
// taken in the cycle after the load: one slot memory read per cycle walks
// the neighbors into a four-stage read, read, multiply, accumulate
// pipeline, then the external field is added and each component saturated.
// The result sits in an output register, so further items are taken while
// it waits. Moments and slots that were never written read as unknown data.
module exchange_field_neighbor_sum_top #(
  parameter int ATOMS         = efns_pkg::DEF_ATOMS,
  parameter int ENSEMBLES     = efns_pkg::DEF_ENSEMBLES,
  parameter int MAX_NEIGHBORS = efns_pkg::DEF_MAX_NEIGHBORS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // site, ensemble, slot, neighbor, coupling, count, vec_x, vec_y, vec_z
  input  logic [efns_pkg::S_TDATA_W-1:0] s_tdata,
  // op
  input  logic [efns_pkg::OP_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_site, out_ensemble, field_x, field_y, field_z
  output logic [efns_pkg::M_TDATA_W-1:0] m_tdata,
  // saturated
  output logic                           m_tuser
);

  efns_pkg::cmd_t    cmd;
  efns_pkg::status_t status;

  efns_ctrl #(
    .ATOMS         (ATOMS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  efns_dpath #(
    .ATOMS         (ATOMS),
    .ENSEMBLES     (ENSEMBLES),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
